FILE: hdl/olc_pkg.sv
// Shared types and constants for the outcode line clipper.
// Used by olc_regs, olc_muldiv and outcode_line_clipper; depends on nothing.
`default_nettype none

package olc_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   localparam logic [3:0] CODE_LEFT   = 4'd1;
   localparam logic [3:0] CODE_RIGHT  = 4'd2;
   localparam logic [3:0] CODE_BOTTOM = 4'd4;
   localparam logic [3:0] CODE_TOP    = 4'd8;

   // The endpoints of a segment are moved onto an edge at most this many times in total.
   localparam int MAX_MOVES = 4;
   localparam int MOVE_W    = $clog2(MAX_MOVES + 1);

   typedef enum logic [1:0] {
      CSR_LEFT,
      CSR_RIGHT,
      CSR_BOTTOM,
      CSR_TOP
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CODE,
      ST_DECIDE,
      ST_WAIT,
      ST_APPLY,
      ST_EMIT
   } clip_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

endpackage

`default_nettype wire

FILE: hdl/outcode_line_clipper.sv
// Cohen-Sutherland polyline clipper. A segment has its endpoints coded, is decided on
// and, for each endpoint move (at most 4), waits on the shared multiply-divide unit
// before the moved endpoint is coded again; a segment found inside is then emitted.
// One item is in work at a time; req_stall is high until the item is finished.
// Synchronous reset clears the rectangle to its defaults, the previous vertex to zero
// with no vertex held, and empties the result register.
`default_nettype none

module outcode_line_clipper #(
   parameter int COORD_WIDTH = olc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_line_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_seg_x0,
   output logic signed [COORD_WIDTH-1:0] rsp_seg_y0,
   output logic signed [COORD_WIDTH-1:0] rsp_seg_x1,
   output logic signed [COORD_WIDTH-1:0] rsp_seg_y1,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  olc_pkg::csr_index_type        csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_wdata
);
   import olc_pkg::*;

   localparam int W = COORD_WIDTH;

   logic signed [W-1:0] clip_left, clip_right, clip_bottom, clip_top;

   clip_state_type      state_ff, state_in;
   logic signed [W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                have_prev_ff, have_prev_in;
   logic signed [W-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [3:0]          c1_ff, c1_in, c2_ff, c2_in;
   logic [MOVE_W-1:0]   moves_ff, moves_in;
   logic signed [W-1:0] b1_ff, b1_in, edge_ff, edge_in;
   logic                neg_ff, neg_in, vert_ff, vert_in, upd1_ff, upd1_in;
   logic                den_zero_ff, den_zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] out_x0_ff, out_y0_ff, out_x1_ff, out_y1_ff;

   logic                accept, out_free, out_load;
   logic [3:0]          c_sel;
   logic                vert;
   logic signed [W-1:0] clip_edge, a1, a2, b1, b2;
   logic signed [W:0]   den, db, dt;
   logic                md_start, md_done, md_rem_nz;
   logic [W:0]          md_a, md_b, md_d, md_quo;
   logic signed [W+1:0] base, base_adj;
   logic signed [W-1:0] moved;

   olc_regs #(.COORD_WIDTH(W)) u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .clip_left   (clip_left),
      .clip_right  (clip_right),
      .clip_bottom (clip_bottom),
      .clip_top    (clip_top)
   );

   olc_muldiv #(.OP_WIDTH(W + 1)) u_muldiv (
      .clock       (clock),
      .reset       (reset),
      .start       (md_start),
      .mul_a       (md_a),
      .mul_b       (md_b),
      .div_d       (md_d),
      .done        (md_done),
      .quotient    (md_quo),
      .rem_nonzero (md_rem_nz)
   );

   function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                          input logic signed [W-1:0] y,
                                          input logic signed [W-1:0] lft,
                                          input logic signed [W-1:0] rgt,
                                          input logic signed [W-1:0] bot,
                                          input logic signed [W-1:0] tp);
      logic [3:0] c;
      c = '0;
      if (x < lft) begin
         c = c | CODE_LEFT;
      end else if (x > rgt) begin
         c = c | CODE_RIGHT;
      end
      if (y < bot) begin
         c = c | CODE_BOTTOM;
      end else if (y > tp) begin
         c = c | CODE_TOP;
      end
      return c;
   endfunction

   function automatic logic [W:0] magnitude(input logic signed [W:0] v);
      return v[W] ? (W+1)'(0) - v : v;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the next move: the top and bottom edges come first.
   assign c_sel = (c1_ff != 4'd0) ? c1_ff : c2_ff;
   assign vert  = ((c_sel & CODE_TOP) != 4'd0) || ((c_sel & CODE_BOTTOM) != 4'd0);

   always_comb begin
      priority if ((c_sel & CODE_TOP) != 4'd0) begin
         clip_edge = clip_top;
      end else if ((c_sel & CODE_BOTTOM) != 4'd0) begin
         clip_edge = clip_bottom;
      end else if ((c_sel & CODE_RIGHT) != 4'd0) begin
         clip_edge = clip_right;
      end else begin
         clip_edge = clip_left;
      end
   end

   assign a1  = vert ? y1_ff : x1_ff;
   assign a2  = vert ? y2_ff : x2_ff;
   assign b1  = vert ? x1_ff : y1_ff;
   assign b2  = vert ? x2_ff : y2_ff;
   assign den = {a2[W-1], a2} - {a1[W-1], a1};
   assign db  = {b2[W-1], b2} - {b1[W-1], b1};
   assign dt  = {clip_edge[W-1], clip_edge} - {a1[W-1], a1};

   assign md_a = magnitude(db);
   assign md_b = magnitude(dt);
   assign md_d = magnitude(den);

   // New coordinate: b1 plus or minus the quotient, then truncated toward zero.
   assign base = neg_ff ? {{2{b1_ff[W-1]}}, b1_ff} - {1'b0, md_quo}
                        : {{2{b1_ff[W-1]}}, b1_ff} + {1'b0, md_quo};

   always_comb begin
      base_adj = base;
      if (md_rem_nz) begin
         if (!neg_ff && base[W+1]) begin
            base_adj = base + 1'b1;
         end else if (neg_ff && !base[W+1] && (base != '0)) begin
            base_adj = base - 1'b1;
         end
      end
   end

   assign moved = den_zero_ff ? b1_ff : base_adj[W-1:0];

   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      moves_in     = moves_ff;
      b1_in        = b1_ff;
      edge_in      = edge_ff;
      neg_in       = neg_ff;
      vert_in      = vert_ff;
      upd1_in      = upd1_ff;
      den_zero_in  = den_zero_ff;
      md_start     = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x1_in        = prev_x_ff;
               y1_in        = prev_y_ff;
               x2_in        = req_point_x;
               y2_in        = req_point_y;
               prev_x_in    = req_point_x;
               prev_y_in    = req_point_y;
               have_prev_in = 1'b1;
               moves_in     = '0;
               if (have_prev_ff && !req_line_start) begin
                  state_in = ST_CODE;
               end
            end
         end
         ST_CODE: begin
            c1_in    = outcode(x1_ff, y1_ff, clip_left, clip_right, clip_bottom, clip_top);
            c2_in    = outcode(x2_ff, y2_ff, clip_left, clip_right, clip_bottom, clip_top);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if ((c1_ff & c2_ff) != 4'd0) begin
               state_in = ST_IDLE;
            end else if ((c1_ff == 4'd0) && (c2_ff == 4'd0)) begin
               state_in = ST_EMIT;
            end else if (moves_ff == MOVE_W'(MAX_MOVES)) begin
               state_in = ST_IDLE;
            end else begin
               md_start    = 1'b1;
               b1_in       = b1;
               edge_in     = clip_edge;
               neg_in      = (db[W] ^ dt[W]) ^ den[W];
               vert_in     = vert;
               upd1_in     = (c1_ff != 4'd0);
               den_zero_in = (den == '0);
               state_in    = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (md_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (upd1_ff) begin
               x1_in = vert_ff ? moved : edge_ff;
               y1_in = vert_ff ? edge_ff : moved;
            end else begin
               x2_in = vert_ff ? moved : edge_ff;
               y2_in = vert_ff ? edge_ff : moved;
            end
            moves_in = moves_ff + 1'b1;
            state_in = ST_CODE;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         moves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         moves_ff     <= moves_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      b1_ff       <= b1_in;
      edge_ff     <= edge_in;
      neg_ff      <= neg_in;
      vert_ff     <= vert_in;
      upd1_ff     <= upd1_in;
      den_zero_ff <= den_zero_in;
      if (out_load) begin
         out_x0_ff <= x1_ff;
         out_y0_ff <= y1_ff;
         out_x1_ff <= x2_ff;
         out_y1_ff <= y2_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_seg_x0 = out_x0_ff;
   assign rsp_seg_y0 = out_y0_ff;
   assign rsp_seg_x1 = out_x1_ff;
   assign rsp_seg_y1 = out_y1_ff;

   // The move counter never runs past its limit.
   a_moves_bound: assert property (@(posedge clock) disable iff (reset)
      moves_ff <= MOVE_W'(MAX_MOVES))
      else $error("move counter exceeded its limit");

   // The divider only reports completion while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside the wait state");

   // An item that opens a polyline forms no segment and leaves the block idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_line_start) |=> (state_ff == ST_IDLE))
      else $error("line start item began a clip");

   // A segment is only emitted with both endpoints inside the rectangle.
   a_emit_inside: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (x1_ff >= clip_left) && (x1_ff <= clip_right) &&
                   (x2_ff >= clip_left) && (x2_ff <= clip_right) &&
                   (y1_ff >= clip_bottom) && (y1_ff <= clip_top) &&
                   (y2_ff >= clip_bottom) && (y2_ff <= clip_top))
      else $error("emitted segment lies outside the clip rectangle");

endmodule

`default_nettype wire

FILE: hdl/olc_regs.sv
// Clip rectangle registers written through the configuration port.
// Depends on olc_pkg for the register index codes.
`default_nettype none

module olc_regs #(
   parameter int COORD_WIDTH = olc_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  olc_pkg::csr_index_type        csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_wdata,
   output logic signed [COORD_WIDTH-1:0] clip_left,
   output logic signed [COORD_WIDTH-1:0] clip_right,
   output logic signed [COORD_WIDTH-1:0] clip_bottom,
   output logic signed [COORD_WIDTH-1:0] clip_top
);
   import olc_pkg::*;

   // The default far edges sit at 1023. A narrower coordinate cannot exceed its own
   // maximum, so that maximum behaves the same as 1023 would.
   localparam logic signed [COORD_WIDTH-1:0] RESET_HI =
      (COORD_WIDTH >= 11) ? COORD_WIDTH'(1023) : {1'b0, {(COORD_WIDTH-1){1'b1}}};

   logic signed [COORD_WIDTH-1:0] left_ff, left_in;
   logic signed [COORD_WIDTH-1:0] right_ff, right_in;
   logic signed [COORD_WIDTH-1:0] bottom_ff, bottom_in;
   logic signed [COORD_WIDTH-1:0] top_ff, top_in;

   assign csr_ready = 1'b1;

   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      top_in    = top_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT:   left_in   = csr_wdata;
            CSR_RIGHT:  right_in  = csr_wdata;
            CSR_BOTTOM: bottom_in = csr_wdata;
            CSR_TOP:    top_in    = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= RESET_HI;
         bottom_ff <= '0;
         top_ff    <= RESET_HI;
      end else begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
   end

   assign clip_left   = left_ff;
   assign clip_right  = right_ff;
   assign clip_bottom = bottom_ff;
   assign clip_top    = top_ff;

endmodule

`default_nettype wire

FILE: hdl/olc_muldiv.sv
// Shared iterative unit computing floor(a*b/d) and whether a remainder is left.
// A multiply step, then a restoring divide of one quotient bit per cycle.
// Depends on olc_pkg for its state type.
`default_nettype none

module olc_muldiv #(
   parameter int OP_WIDTH = olc_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OP_WIDTH-1:0] mul_a,
   input  logic [OP_WIDTH-1:0] mul_b,
   input  logic [OP_WIDTH-1:0] div_d,
   output logic                done,
   output logic [OP_WIDTH-1:0] quotient,
   output logic                rem_nonzero
);
   import olc_pkg::*;

   localparam int CNT_W = $clog2(OP_WIDTH);

   md_state_type                state_ff, state_in;
   logic [OP_WIDTH-1:0]         a_ff, a_in;
   logic [OP_WIDTH-1:0]         b_ff, b_in;
   logic [OP_WIDTH-1:0]         d_ff, d_in;
   logic [OP_WIDTH-1:0]         rem_ff, rem_in;
   logic [OP_WIDTH-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [2*OP_WIDTH-1:0]       product;
   logic [OP_WIDTH:0]           trial;
   logic [OP_WIDTH+1:0]         diff;

   assign product = a_ff * b_ff;
   // The quotient is known to fit OP_WIDTH bits, so the upper product half is
   // already below the divisor and only the lower half needs shifting in.
   assign trial   = {rem_ff, quo_ff[OP_WIDTH-1]};
   assign diff    = {1'b0, trial} - {2'b00, d_ff};

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               a_in     = mul_a;
               b_in     = mul_b;
               d_in     = div_d;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            rem_in   = product[2*OP_WIDTH-1:OP_WIDTH];
            quo_in   = product[OP_WIDTH-1:0];
            cnt_in   = '0;
            state_in = MD_DIV;
         end
         MD_DIV: begin
            if (!diff[OP_WIDTH+1]) begin
               rem_in = diff[OP_WIDTH-1:0];
            end else begin
               rem_in = trial[OP_WIDTH-1:0];
            end
            quo_in = {quo_ff[OP_WIDTH-2:0], ~diff[OP_WIDTH+1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OP_WIDTH - 1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);

endmodule

`default_nettype wire
